/* rtl/core/c8alu_pkg.sv */
// Shared types and constants for the 8-bit accumulator ALU.
package c8alu_pkg;

    // Operation codes
    localparam logic [3:0] CMD_ADD = 4'd0;
    localparam logic [3:0] CMD_ADC = 4'd1;
    localparam logic [3:0] CMD_SUB = 4'd2;
    localparam logic [3:0] CMD_SBC = 4'd3;
    localparam logic [3:0] CMD_AND = 4'd4;
    localparam logic [3:0] CMD_XOR = 4'd5;
    localparam logic [3:0] CMD_OR  = 4'd6;
    localparam logic [3:0] CMD_CP  = 4'd7;
    localparam logic [3:0] CMD_INC = 4'd8;
    localparam logic [3:0] CMD_DEC = 4'd9;
    localparam logic [3:0] CMD_CPL = 4'd10;
    localparam logic [3:0] CMD_DAA = 4'd11;

    // Flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // DAA constants
    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

    typedef struct packed {
        logic [7:0] acc;
        logic [3:0] flags;
        logic [7:0] incdec;
    } t_alu_res;

endpackage

/* rtl/core/c8alu_core.sv */
// Combinational datapath: one operation on accumulator, flags and operand.
module c8alu_core (
    input  logic [3:0]          i_cmd,
    input  logic [7:0]          i_operand,
    input  logic [7:0]          i_acc,
    input  logic [3:0]          i_flags,
    output c8alu_pkg::t_alu_res o_res
);

    logic       cin;
    logic [8:0] sum9;
    logic [4:0] sum_lo;
    logic [8:0] diff9;
    logic [4:0] diff_lo;
    logic [7:0] inc_v;
    logic [7:0] dec_v;
    logic [7:0] daa_a;
    logic [7:0] daa_b;
    logic       daa_c;
    logic [7:0] acc_n;
    logic [3:0] flg_n;
    logic [7:0] incdec_n;

    always_comb begin
        cin = ((i_cmd == c8alu_pkg::CMD_ADC) || (i_cmd == c8alu_pkg::CMD_SBC))
            ? i_flags[c8alu_pkg::FLAG_C] : 1'b0;
        sum9    = {1'b0, i_acc} + {1'b0, i_operand} + {8'd0, cin};
        sum_lo  = {1'b0, i_acc[3:0]} + {1'b0, i_operand[3:0]} + {4'd0, cin};
        // bit 8 / bit 4 of the wrapped difference is the borrow
        diff9   = {1'b0, i_acc} - {1'b0, i_operand} - {8'd0, cin};
        diff_lo = {1'b0, i_acc[3:0]} - {1'b0, i_operand[3:0]} - {4'd0, cin};
        inc_v   = i_operand + 8'd1;
        dec_v   = i_operand - 8'd1;
    end

    // Decimal adjust: N picks the add or the subtract form
    always_comb begin
        daa_a = i_acc;
        daa_c = i_flags[c8alu_pkg::FLAG_C];
        if (!i_flags[c8alu_pkg::FLAG_N]) begin
            if (i_flags[c8alu_pkg::FLAG_C] || (i_acc > c8alu_pkg::DAA_HI_LIMIT)) begin
                daa_a = i_acc + c8alu_pkg::DAA_HI_ADJ;
                daa_c = 1'b1;
            end
            if (i_flags[c8alu_pkg::FLAG_H] || (daa_a[3:0] > c8alu_pkg::DAA_LO_LIMIT)) begin
                daa_b = daa_a + c8alu_pkg::DAA_LO_ADJ;
            end else begin
                daa_b = daa_a;
            end
        end else begin
            if (i_flags[c8alu_pkg::FLAG_C]) begin
                daa_a = i_acc - c8alu_pkg::DAA_HI_ADJ;
            end
            if (i_flags[c8alu_pkg::FLAG_H]) begin
                daa_b = daa_a - c8alu_pkg::DAA_LO_ADJ;
            end else begin
                daa_b = daa_a;
            end
        end
    end

    always_comb begin
        acc_n    = i_acc;
        flg_n    = i_flags;
        incdec_n = 8'd0;
        unique case (i_cmd)
            c8alu_pkg::CMD_ADD, c8alu_pkg::CMD_ADC: begin
                acc_n = sum9[7:0];
                flg_n = {(sum9[7:0] == 8'd0), 1'b0, sum_lo[4], sum9[8]};
            end
            c8alu_pkg::CMD_SUB, c8alu_pkg::CMD_SBC: begin
                acc_n = diff9[7:0];
                flg_n = {(diff9[7:0] == 8'd0), 1'b1, diff_lo[4], diff9[8]};
            end
            c8alu_pkg::CMD_CP: begin
                flg_n = {(diff9[7:0] == 8'd0), 1'b1, diff_lo[4], diff9[8]};
            end
            c8alu_pkg::CMD_AND: begin
                acc_n = i_acc & i_operand;
                flg_n = {(acc_n == 8'd0), 1'b0, 1'b1, 1'b0};
            end
            c8alu_pkg::CMD_XOR: begin
                acc_n = i_acc ^ i_operand;
                flg_n = {(acc_n == 8'd0), 1'b0, 1'b0, 1'b0};
            end
            c8alu_pkg::CMD_OR: begin
                acc_n = i_acc | i_operand;
                flg_n = {(acc_n == 8'd0), 1'b0, 1'b0, 1'b0};
            end
            c8alu_pkg::CMD_INC: begin
                incdec_n = inc_v;
                flg_n = {(inc_v == 8'd0), 1'b0, (i_operand[3:0] == 4'hF),
                         i_flags[c8alu_pkg::FLAG_C]};
            end
            c8alu_pkg::CMD_DEC: begin
                incdec_n = dec_v;
                flg_n = {(dec_v == 8'd0), 1'b1, (i_operand[3:0] == 4'h0),
                         i_flags[c8alu_pkg::FLAG_C]};
            end
            c8alu_pkg::CMD_CPL: begin
                acc_n = ~i_acc;
                flg_n = {i_flags[c8alu_pkg::FLAG_Z], 1'b1, 1'b1,
                         i_flags[c8alu_pkg::FLAG_C]};
            end
            c8alu_pkg::CMD_DAA: begin
                acc_n = daa_b;
                flg_n = {(daa_b == 8'd0), i_flags[c8alu_pkg::FLAG_N], 1'b0, daa_c};
            end
            default: begin
                // unused codes: no operation
                acc_n = i_acc;
                flg_n = i_flags;
            end
        endcase
    end

    assign o_res.acc    = acc_n;
    assign o_res.flags  = flg_n;
    assign o_res.incdec = ((i_cmd == c8alu_pkg::CMD_INC) || (i_cmd == c8alu_pkg::CMD_DEC))
                        ? incdec_n : acc_n;

endmodule

/* rtl/core/cpu_8bit_alu_with_flags.sv */
// Top level: 8-bit accumulator ALU with flags, input register and result register.
//
//  channel  direction  handshake           payload
//  in       to block   i_valid / o_ready   i_cmd, i_operand
//  out      from block o_valid / i_ready   o_acc_out, o_flags_out, o_incdec_value
//
// One operation per cycle sustained while the output is not stalled. An input
// transfer loads the input register; the datapath then feeds the result register,
// whose valid bit drives o_valid.
// The accumulator and flags update when an operation moves into the result
// register, so consecutive operations chain with no gap.
// Reset (synchronous, active low) clears accumulator, flags and both valid bits.
// A stalled output holds both stages; o_ready stays high while a stage can move.
module cpu_8bit_alu_with_flags (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [3:0] i_cmd,
    input  logic [7:0] i_operand,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_acc_out,
    output logic [3:0] o_flags_out,
    output logic [7:0] o_incdec_value
);

    logic                r_in_valid;
    logic [3:0]          r_cmd;
    logic [7:0]          r_operand;
    logic [7:0]          r_acc;
    logic [3:0]          r_flags;
    logic                r_out_valid;
    c8alu_pkg::t_alu_res r_res;
    c8alu_pkg::t_alu_res n_res;
    logic                advance;
    logic                in_take;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    c8alu_core u_core (
        .i_cmd     (r_cmd),
        .i_operand (r_operand),
        .i_acc     (r_acc),
        .i_flags   (r_flags),
        .o_res     (n_res)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd     <= i_cmd;
            r_operand <= i_operand;
        end
    end

    // architectural state and result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= 8'd0;
            r_flags     <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_acc       <= n_res.acc;
                r_flags     <= n_res.flags;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_acc_out      = r_res.acc;
    assign o_flags_out    = r_res.flags;
    assign o_incdec_value = r_res.incdec;

    // Shown result always matches the architectural state
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_acc_out == r_acc) && (o_flags_out == r_flags))
        else $error("result register differs from accumulator/flags");

    // State only changes when an operation enters the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_acc) && $stable(r_flags))
        else $error("accumulator or flags changed without a transfer");

    // INC and DEC leave the accumulator alone
    a_incdec_keeps_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && ((r_cmd == c8alu_pkg::CMD_INC) || (r_cmd == c8alu_pkg::CMD_DEC))
        |=> (r_acc == $past(r_acc)))
        else $error("INC/DEC altered the accumulator");

endmodule
